@@ sv/bcr_pkg.sv @@
// Shared types, sizes and codes for the bitmap circle reveal block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package bcr_pkg;

   // Grid store dimensions
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

   // Field widths
   localparam int CSR_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int MODE_W    = 2;
   localparam int CRD_W     = 13;
   localparam int RAD_W     = CRD_W - 1;
   localparam int QRY_W     = 8;

   // Derived widths
   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int ACT_W  = ($clog2(MAX_DIM + 1) > CSR_W) ? $clog2(MAX_DIM + 1) : CSR_W;
   localparam int QA_W   = (ACT_W > QRY_W) ? ACT_W : QRY_W;
   localparam int DX_W   = $clog2(MAX_DIM * 16 + (1 << (CRD_W - 1))) + 1;
   localparam int SQ_W   = 2 * DX_W - 2;
   localparam int PROD_W = 2 * CRD_W;

   // Register reset values
   localparam logic [CSR_W-1:0] GRID_WIDTH_RST  = CSR_W'(64);
   localparam logic [CSR_W-1:0] GRID_HEIGHT_RST = CSR_W'(64);

   typedef enum logic [MODE_W-1:0] {
      MODE_CIRCLE = 2'd0,
      MODE_HIDE   = 2'd1,
      MODE_FILL   = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 1'd0,
      CSR_GRID_HEIGHT = 1'd1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_CX,
      ST_SQ_CY,
      ST_SQ_R,
      ST_SCAN,
      ST_ROW_WR,
      ST_FILL,
      ST_HIDE,
      ST_QRY_READ,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_item;
      logic sq_cx;
      logic sq_cy;
      logic sq_r;
      logic row_init;
      logic scan_step;
      logic row_write;
      logic fill_write;
      logic hide_all;
      logic rsp_load;
   } bcr_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     grid_empty;
      logic     col_last;
      logic     row_last;
      logic     fill_last;
      logic     rsp_free;
   } bcr_status_type;

endpackage

`default_nettype wire

@@ sv/bcr_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Self-contained; no package needed.
`default_nettype none

module bcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/bcr_ctrl.sv @@
// Sequencer for the bitmap circle reveal block: one item at a time.
// Depends on bcr_pkg for the state, command and status types.
`default_nettype none

module bcr_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [bcr_pkg::MODE_W-1:0]    req_mode,
   input  wire bcr_pkg::bcr_status_type       status,
   output bcr_pkg::bcr_cmd_type               cmd
);

   import bcr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               unique case (mode_type'(req_mode))
                  MODE_CIRCLE: state_in = ST_SQ_CX;
                  MODE_HIDE:   state_in = ST_HIDE;
                  MODE_FILL:   state_in = ST_FILL;
                  MODE_QUERY:  state_in = ST_QRY_READ;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_SQ_CX: begin
            cmd.sq_cx = 1'b1;
            state_in  = ST_SQ_CY;
         end
         ST_SQ_CY: begin
            cmd.sq_cy = 1'b1;
            state_in  = ST_SQ_R;
         end
         ST_SQ_R: begin
            cmd.sq_r     = 1'b1;
            cmd.row_init = 1'b1;
            state_in     = status.grid_empty ? ST_FINISH : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.col_last) begin
               state_in = ST_ROW_WR;
            end
         end
         ST_ROW_WR: begin
            cmd.row_write = 1'b1;
            state_in      = status.row_last ? ST_FINISH : ST_SCAN;
         end
         ST_FILL: begin
            cmd.fill_write = 1'b1;
            if (status.fill_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_HIDE: begin
            cmd.hide_all = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_QRY_READ: begin
            // wait out the registered read of the addressed row
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/bcr_datapath.sv @@
// Datapath of the bitmap circle reveal block: size registers, item capture,
// incremental circle test, row-wide map store with row valid bits, result register.
// Depends on bcr_pkg and bcr_ram.
`default_nettype none

module bcr_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_en,
   input  wire logic [bcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bcr_pkg::CSR_W-1:0]         csr_wdata,
   input  wire logic [bcr_pkg::MODE_W-1:0]        req_mode,
   input  wire logic signed [bcr_pkg::CRD_W-1:0]  req_center_x,
   input  wire logic signed [bcr_pkg::CRD_W-1:0]  req_center_y,
   input  wire logic [bcr_pkg::RAD_W-1:0]         req_radius,
   input  wire logic signed [bcr_pkg::QRY_W-1:0]  req_query_col,
   input  wire logic signed [bcr_pkg::QRY_W-1:0]  req_query_row,
   input  wire bcr_pkg::bcr_cmd_type              cmd,
   output bcr_pkg::bcr_status_type                status,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_revealed
);

   import bcr_pkg::*;

   logic [CSR_W-1:0]        grid_width_ff;
   logic [CSR_W-1:0]        grid_height_ff;
   logic [ACT_W-1:0]        cols_act;
   logic [ACT_W-1:0]        rows_act;

   mode_type                mode_ff;
   logic signed [CRD_W-1:0] cx_ff;
   logic signed [CRD_W-1:0] cy_ff;
   logic [RAD_W-1:0]        rad_ff;
   logic [COL_W-1:0]        q_col_ff;
   logic                    q_hit_ff;
   logic                    q_hit_in;

   logic signed [CRD_W-1:0]  mul_op;
   logic signed [PROD_W-1:0] mul_prod;
   logic [SQ_W-1:0]          sq_val;

   logic [SQ_W-1:0]         cx2_ff;
   logic [SQ_W-1:0]         r2_ff;
   logic [SQ_W-1:0]         dx2_ff;
   logic [SQ_W-1:0]         dy2_ff;
   logic [SQ_W-1:0]         dx2_in;
   logic [SQ_W-1:0]         dy2_in;
   logic signed [DX_W-1:0]  dx_ff;
   logic signed [DX_W-1:0]  dy_ff;
   logic signed [SQ_W:0]    dx_inc;
   logic signed [SQ_W:0]    dy_inc;
   logic [SQ_W:0]           dist_sum;
   logic                    in_circle;

   logic [COL_W-1:0]        col_cnt_ff;
   logic [ROW_W-1:0]        row_cnt_ff;
   logic [MAX_WIDTH-1:0]    mask_ff;
   logic [MAX_HEIGHT-1:0]   row_valid_ff;

   logic                    ram_wr_en;
   logic [MAX_WIDTH-1:0]    ram_wr_data;
   logic [MAX_WIDTH-1:0]    ram_rd_data;
   logic [MAX_WIDTH-1:0]    row_base;

   logic                    rsp_valid_ff;
   logic                    rsp_revealed_ff;
   logic                    query_bit;

   // Size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RST;
         grid_height_ff <= GRID_HEIGHT_RST;
      end else if (csr_write_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
            CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Saturate the active area at the store size
   assign cols_act = (ACT_W'(grid_width_ff) > ACT_W'(MAX_WIDTH)) ?
                     ACT_W'(MAX_WIDTH) : ACT_W'(grid_width_ff);
   assign rows_act = (ACT_W'(grid_height_ff) > ACT_W'(MAX_HEIGHT)) ?
                     ACT_W'(MAX_HEIGHT) : ACT_W'(grid_height_ff);

   assign q_hit_in = !req_query_col[QRY_W-1] && !req_query_row[QRY_W-1] &&
                     (QA_W'(unsigned'(req_query_col)) < QA_W'(cols_act)) &&
                     (QA_W'(unsigned'(req_query_row)) < QA_W'(rows_act));

   // Shared squarer for cx, cy and radius
   always_comb begin
      if (cmd.sq_cx) begin
         mul_op = cx_ff;
      end else if (cmd.sq_cy) begin
         mul_op = cy_ff;
      end else begin
         mul_op = $signed({1'b0, rad_ff});
      end
   end

   assign mul_prod = mul_op * mul_op;
   assign sq_val   = SQ_W'(mul_prod);

   // Advancing by one cell adds 16 to the offset: d^2 grows by 32*d + 256
   assign dx_inc = ((SQ_W + 1)'(dx_ff) <<< 5) + (SQ_W + 1)'(256);
   assign dy_inc = ((SQ_W + 1)'(dy_ff) <<< 5) + (SQ_W + 1)'(256);
   assign dx2_in = SQ_W'($signed({1'b0, dx2_ff}) + dx_inc);
   assign dy2_in = SQ_W'($signed({1'b0, dy2_ff}) + dy_inc);

   assign dist_sum  = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign in_circle = (dist_sum <= {1'b0, r2_ff});

   // Item capture and scan registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff  <= mode_type'(req_mode);
         cx_ff    <= req_center_x;
         cy_ff    <= req_center_y;
         rad_ff   <= req_radius;
         q_col_ff <= req_query_col[COL_W-1:0];
         q_hit_ff <= q_hit_in;
         if (mode_type'(req_mode) == MODE_QUERY) begin
            row_cnt_ff <= req_query_row[ROW_W-1:0];
         end else begin
            row_cnt_ff <= '0;
         end
      end
      if (cmd.sq_cx) begin
         cx2_ff <= sq_val;
      end
      if (cmd.sq_cy) begin
         dy2_ff <= sq_val;
      end
      if (cmd.sq_r) begin
         r2_ff <= sq_val;
      end
      if (cmd.row_init) begin
         dy_ff <= -DX_W'(cy_ff);
      end
      if (cmd.row_init || cmd.row_write) begin
         col_cnt_ff <= '0;
         dx_ff      <= -DX_W'(cx_ff);
         dx2_ff     <= cx2_ff;
         mask_ff    <= '0;
      end
      if (cmd.scan_step) begin
         mask_ff[col_cnt_ff] <= in_circle;
         col_cnt_ff          <= col_cnt_ff + COL_W'(1);
         dx_ff               <= dx_ff + DX_W'(16);
         dx2_ff              <= dx2_in;
      end
      if (cmd.row_write) begin
         row_cnt_ff <= row_cnt_ff + ROW_W'(1);
         dy_ff      <= dy_ff + DX_W'(16);
         dy2_ff     <= dy2_in;
      end
      if (cmd.fill_write) begin
         row_cnt_ff <= row_cnt_ff + ROW_W'(1);
      end
   end

   // Row valid bits: an invalid row reads as all hidden
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.hide_all) begin
         row_valid_ff <= '0;
      end else if (cmd.row_write || cmd.fill_write) begin
         row_valid_ff[row_cnt_ff] <= 1'b1;
      end
   end

   assign row_base    = row_valid_ff[row_cnt_ff] ? ram_rd_data : '0;
   assign ram_wr_en   = cmd.row_write || cmd.fill_write;
   assign ram_wr_data = cmd.fill_write ? '1 : (row_base | mask_ff);

   bcr_ram #(
      .WIDTH (MAX_WIDTH),
      .DEPTH (MAX_HEIGHT)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (row_cnt_ff),
      .wr_data (ram_wr_data),
      .rd_addr (row_cnt_ff),
      .rd_data (ram_rd_data)
   );

   assign query_bit = (mode_ff == MODE_QUERY) && q_hit_ff &&
                      row_valid_ff[row_cnt_ff] && ram_rd_data[q_col_ff];

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_revealed_ff <= query_bit;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_revealed = rsp_revealed_ff;

   assign status.mode       = mode_ff;
   assign status.grid_empty = (cols_act == '0) || (rows_act == '0);
   assign status.col_last   = (ACT_W'(col_cnt_ff) == (cols_act - ACT_W'(1)));
   assign status.row_last   = (ACT_W'(row_cnt_ff) == (rows_act - ACT_W'(1)));
   assign status.fill_last  = (row_cnt_ff == ROW_W'(MAX_HEIGHT - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

@@ sv/bitmap_circle_reveal_top.sv @@
// Bitmap circle reveal top: reveal map with circle, hide, fill and query; uses bcr_pkg,
// bcr_ctrl, bcr_datapath and bcr_ram. A circle over an empty active area skips the scan.
// One transaction at a time: the next is accepted once the last result has been loaded
// into the output register, even while that result still waits to be taken.
// Reset: sizes go to 64x64 and all row valid bits clear at once, so the map reads hidden.
`default_nettype none

module bitmap_circle_reveal_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // register write port
   input  wire logic                              csr_write_en,
   input  wire logic [bcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bcr_pkg::CSR_W-1:0]         csr_wdata,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [bcr_pkg::MODE_W-1:0]        req_mode,
   input  wire logic signed [bcr_pkg::CRD_W-1:0]  req_center_x,
   input  wire logic signed [bcr_pkg::CRD_W-1:0]  req_center_y,
   input  wire logic [bcr_pkg::RAD_W-1:0]         req_radius,
   input  wire logic signed [bcr_pkg::QRY_W-1:0]  req_query_col,
   input  wire logic signed [bcr_pkg::QRY_W-1:0]  req_query_row,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_revealed
);

   import bcr_pkg::*;

   // Command and status between sequencer and datapath
   bcr_cmd_type    cmd;
   bcr_status_type status;

   // Sequencer: accepts a transaction in idle, steps squaring, scan and row write-back,
   // fill sweep, hide or query read, then hands the result to the output register.
   bcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: the map is stored one row per word; a circle row is read,
   // OR-ed with the mask built over the scan and written back.
   bcr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_mode      (req_mode),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_radius    (req_radius),
      .req_query_col (req_query_col),
      .req_query_row (req_query_row),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_revealed  (rsp_revealed)
   );

`ifndef SYNTHESIS
   // Only one transaction in flight: ready drops right after an accept
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a transaction is in flight");

   // Never overwrite a result that has not been taken
   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("result loaded into an occupied output register");

   // Only a query reports a revealed cell
   a_non_query_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && status.mode != MODE_QUERY) |=> !rsp_revealed)
      else $error("non-query transaction returned a set bit");

   // The scan never runs over an empty grid
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> !status.grid_empty)
      else $error("circle scan started on an empty grid");
`endif

endmodule

`default_nettype wire
